// File: src/polyper_pkg.sv
`default_nettype none
package polyper_pkg;

  // polygon index and count width, fixed by the output format
  localparam int IDX_BITS = 16;

  // handshake between the sequencer and the square root unit
  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage
`default_nettype wire

// File: src/polyper_sqrt.sv
`default_nettype none
module polyper_sqrt #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire                                              clk,
  input  wire                                              rst_n,
  input  wire                                              start,
  input  wire  [2*COORD_BITS:0]                            radicand,
  output logic [(2*COORD_BITS+2*FRAC_BITS+2)/2-1:0]        root,
  output polyper_pkg::sqrt_stat_t                          stat
);
  import polyper_pkg::*;

  localparam int SQ_W   = 2*COORD_BITS + 1;
  localparam int RAD_W  = SQ_W + 2*FRAC_BITS;
  localparam int N      = (RAD_W + 1) / 2;
  localparam int RAD2_W = 2*N;
  localparam int RW     = N + 2;
  localparam int CNT_W  = $clog2(N);

  logic [RAD2_W-1:0] rad_r;
  logic [RW-1:0]     rem_r;
  logic [N-1:0]      root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [RW-1:0]     rem_sh;
  logic [RW-1:0]     trial;
  logic              take;

  // one result bit per cycle: bring down two radicand bits, try (root<<2)|1
  assign rem_sh = {rem_r[RW-3:0], rad_r[RAD2_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign take   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(N-1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= RAD2_W'(radicand) << (2*FRAC_BITS);
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= rad_r << 2;
      if (take) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[N-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[N-2:0], 1'b0};
      end
    end
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

// File: src/polygon_perimeter_min_select_core.sv
`default_nettype none
// Each edge runs through two squaring states, a start state, the bit-serial square root (one
// step per root bit, ROOT_W = 25 by default) and an accumulate once the root is done. A vertex
// that opens a polygon without closing it is only stored; a middle vertex runs one edge; a
// closing vertex runs two (a lone vertex only its zero-length closing edge), then the minimum
// update and the result word load. One vertex at a time: all edges share one square root unit.
// Reset: synchronous, active low; clears the open polygon, count and index, minimum to all ones.
module polygon_perimeter_min_select_core #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8,
  parameter int SUM_BITS   = 32
) (
  input  wire                                                          clk,
  input  wire                                                          rst_n,
  input  wire                                                          in_tvalid,
  output logic                                                         in_tready,
  // vertex_x, vertex_y
  input  wire  [((2*COORD_BITS+7)/8)*8-1:0]                            in_tdata,
  input  wire                                                          in_tlast,
  // new_set
  input  wire                                                          in_tuser,
  output logic                                                         out_tvalid,
  input  wire                                                          out_tready,
  // perimeter, figure_index, smallest_perimeter, smallest_index
  output logic [((2*SUM_BITS+2*polyper_pkg::IDX_BITS+7)/8)*8-1:0]      out_tdata,
  // overflowed
  output logic                                                         out_tuser
);
  import polyper_pkg::*;

  localparam int SQ_W   = 2*COORD_BITS + 1;
  localparam int ROOT_W = (2*COORD_BITS + 2*FRAC_BITS + 2) / 2;
  localparam int ACC_W  = ((ROOT_W > SUM_BITS) ? ROOT_W : SUM_BITS) + 1;
  localparam int OUT_W  = 2*SUM_BITS + 2*IDX_BITS;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQX   = 3'd1;
  localparam logic [2:0] S_SQY   = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_ROOT  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  function automatic logic [COORD_BITS-1:0] abs_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [COORD_BITS:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    if (d[COORD_BITS]) d = -d;
    return d[COORD_BITS-1:0];
  endfunction

  logic [2:0]                   state_r;
  logic signed [COORD_BITS-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic                         in_poly_r;
  logic [SUM_BITS-1:0]          sum_r;
  logic                         sat_r;
  logic [IDX_BITS-1:0]          count_r;
  logic [SUM_BITS-1:0]          best_r;
  logic [IDX_BITS-1:0]          best_idx_r;
  logic                         last_r;
  logic                         closing_r;
  logic [COORD_BITS-1:0]        dx_r, dy_r;
  logic [SQ_W-1:0]              sq_r;
  logic                         out_valid_r;
  logic [OUT_TW-1:0]            out_data_r;
  logic                         out_user_r;

  logic signed [COORD_BITS-1:0] vx, vy;
  logic                         in_acc;
  logic                         sqrt_start;
  logic [ROOT_W-1:0]            root;
  sqrt_stat_t                   sqrt_stat;
  logic [ACC_W-1:0]             acc_sum;
  logic                         acc_ovf;
  logic                         out_free;
  logic                         is_less;

  assign vx        = in_tdata[COORD_BITS-1:0];
  assign vy        = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign sqrt_start = (state_r == S_START);

  assign acc_sum  = ACC_W'(sum_r) + ACC_W'(root);
  assign acc_ovf  = (acc_sum > ACC_W'({SUM_BITS{1'b1}}));
  assign out_free = !out_valid_r || out_tready;
  assign is_less  = (sum_r < best_r);

  polyper_sqrt #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sq_r),
    .root     (root),
    .stat     (sqrt_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      first_x_r  <= '0;
      first_y_r  <= '0;
      prev_x_r   <= '0;
      prev_y_r   <= '0;
      in_poly_r  <= 1'b0;
      sum_r      <= '0;
      sat_r      <= 1'b0;
      count_r    <= '0;
      best_r     <= '1;
      best_idx_r <= '0;
      last_r     <= 1'b0;
      closing_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            prev_x_r <= vx;
            prev_y_r <= vy;
            last_r   <= in_tlast;
            if (!in_poly_r) begin
              if (in_tuser) begin
                count_r    <= '0;
                best_r     <= '1;
                best_idx_r <= '0;
              end
              first_x_r <= vx;
              first_y_r <= vy;
              sum_r     <= '0;
              sat_r     <= 1'b0;
              if (in_tlast) begin
                // single vertex: closing edge has zero length
                dx_r      <= '0;
                dy_r      <= '0;
                closing_r <= 1'b1;
                state_r   <= S_SQX;
              end else begin
                in_poly_r <= 1'b1;
              end
            end else begin
              dx_r      <= abs_diff(prev_x_r, vx);
              dy_r      <= abs_diff(prev_y_r, vy);
              closing_r <= 1'b0;
              state_r   <= S_SQX;
            end
          end
        end
        S_SQX: begin
          sq_r    <= SQ_W'(dx_r * dx_r);
          state_r <= S_SQY;
        end
        S_SQY: begin
          sq_r    <= sq_r + SQ_W'(dy_r * dy_r);
          state_r <= S_START;
        end
        S_START: begin
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (sqrt_stat.done) begin
            if (acc_ovf) begin
              sum_r <= '1;
              sat_r <= 1'b1;
            end else begin
              sum_r <= acc_sum[SUM_BITS-1:0];
            end
            if (closing_r) begin
              state_r <= S_FIN;
            end else if (last_r) begin
              // prev holds this vertex now: close back to the first one
              dx_r      <= abs_diff(prev_x_r, first_x_r);
              dy_r      <= abs_diff(prev_y_r, first_y_r);
              closing_r <= 1'b1;
              state_r   <= S_SQX;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            if (is_less) begin
              best_r     <= sum_r;
              best_idx_r <= count_r;
            end
            count_r   <= count_r + 1'b1;
            in_poly_r <= 1'b0;
            state_r   <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // output word register: hold until taken, load when the polygon closes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (state_r == S_FIN && out_free) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_data_r <= OUT_TW'({
        (is_less ? count_r : best_idx_r),
        (is_less ? sum_r   : best_r),
        count_r,
        sum_r
      });
      out_user_r <= sat_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire
